>>> rtl/core/aes_pkg.sv
// Shared types, constants and functions of the AES-CBC block engine.
package aes_pkg;

  localparam int NR_MAX = 14;

  typedef logic [7:0]   byte_t;
  typedef logic [127:0] blk_t;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_KEY0  = 3'd1;
  localparam logic [2:0] REG_KEY3  = 3'd4;
  localparam logic [2:0] REG_IVH   = 3'd5;
  localparam logic [2:0] REG_IVL   = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       key_clear;
    logic       key_step;
    logic       load;
    logic       round;
    logic       final_rnd;
    logic       finish;
    logic [3:0] rk_idx;
  } ctl_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t inv_sbox(input byte_t v);
    byte_t r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of a block, byte 0 in the top bits.
  function automatic byte_t bget(input blk_t b, input int k);
    return b[127-8*k -: 8];
  endfunction

endpackage

>>> rtl/core/aes256_cbc_block_engine.sv
// Top level of the AES CBC block engine: registers, channels and assertions.
//
// One 128-bit block goes in on the in_ channel and one result block comes
// out on the out_ channel, in CBC mode, encrypting or decrypting as the mode
// register says. Key, IV and mode are to be written by the user through the
// cfg_ channel while the engine is idle; the block itself does not enforce it.
// An accepted item is loaded at the accepting edge, then NR rounds run
// through the single round unit, and a finish step registers the result,
// adding the chain when decrypting and counting the padding of a last block.
// One block is in flight at a time: a new item is taken only once the
// engine is back in idle after the last one.
// After reset, and after any key write, the key schedule computes its
// 4*(NR+1) words (60 for a 256-bit key), one word a cycle, and in_tready
// stays low meanwhile. The chain register resets to zero.
// While the receiver stalls, the result waits in the output register and
// no new item is taken; one can be taken at the edge that delivers it.
module aes256_cbc_block_engine #(
  parameter int KEY_BITS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // block_high, block_low
  input  logic         in_tuser,  // first_block
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata, // result_high, result_low, kept_bytes, zero fill
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  localparam int NK = KEY_BITS / 32;
  localparam int NR = NK + 6;

  logic         mode_r;
  logic [63:0]  key_r [4];
  logic [63:0]  ivh_r, ivl_r;
  logic         dirty_r, ovalid_r, accept_ok, in_fire, out_hold;
  logic [127:0] res;
  logic [4:0]   kept;
  logic         res_last;
  aes_pkg::ctl_t ctl;

  assign cfg_ready = 1'b1;
  assign in_tready = accept_ok;
  assign in_fire   = in_tvalid && accept_ok;
  assign out_hold  = ovalid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      ivh_r   <= '0;
      ivl_r   <= '0;
      dirty_r <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else begin
      if (ctl.key_clear) dirty_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          aes_pkg::REG_MODE: mode_r <= cfg_data[0];
          aes_pkg::REG_IVH:  ivh_r  <= cfg_data;
          aes_pkg::REG_IVL:  ivl_r  <= cfg_data;
          default: begin
            if (cfg_index >= aes_pkg::REG_KEY0 && cfg_index <= aes_pkg::REG_KEY3) begin
              key_r[2'(cfg_index - aes_pkg::REG_KEY0)] <= cfg_data;
              dirty_r <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (ctl.finish) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  aes_ctrl #(.NR(NR), .NW(4*(NR+1))) u_ctrl (
    .clk(clk), .rst_n(rst_n), .key_dirty(dirty_r), .in_fire(in_fire),
    .out_busy(out_hold), .decrypt(mode_r), .accept_ok(accept_ok), .ctl(ctl)
  );

  aes_dp #(.NK(NK), .NR(NR)) u_dp (
    .clk(clk), .key({key_r[0], key_r[1], key_r[2], key_r[3]}), .iv({ivh_r, ivl_r}),
    .decrypt(mode_r), .rst_chain(rst_n), .ctl(ctl),
    .in_blk({in_tdata[63:0], in_tdata[127:64]}),
    .in_first(in_tuser), .in_last(in_tlast), .res(res), .kept(kept),
    .res_last(res_last)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {3'd0, kept, res[63:0], res[127:64]};
  assign out_tlast  = res_last;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_tready) |-> !in_tready) else $error("item taken while result pending");
  a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (kept >= 5'd1 && kept <= 5'd16)) else $error("kept out of range");
  a_no_accept_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    dirty_r |-> !in_tready) else $error("item taken with stale keys");
`endif
endmodule

>>> rtl/core/aes_ctrl.sv
// Controller state machine: key expansion sweep and round sequencing.
module aes_ctrl #(
  parameter int NR = 14,
  parameter int NW = 60
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          key_dirty,
  input  logic          in_fire,
  input  logic          out_busy,
  input  logic          decrypt,
  output logic          accept_ok,
  output aes_pkg::ctl_t ctl
);
  localparam logic [1:0] S_KEY  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_KEY;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    accept_ok = 1'b0;
    case (state_r)
      S_KEY: begin
        ctl.key_step = 1'b1;
        ctl.key_clear = (cnt_r == 6'd0);
        if (cnt_r == 6'(NW - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_IDLE: begin
        if (key_dirty) begin
          state_nxt = S_KEY;
          cnt_nxt   = '0;
        end else begin
          accept_ok = !out_busy;
          ctl.rk_idx = decrypt ? 4'(NR) : 4'd0;
          if (in_fire) begin
            ctl.load  = 1'b1;
            state_nxt = S_RUN;
            cnt_nxt   = 6'd1;
          end
        end
      end
      S_RUN: begin
        ctl.round     = 1'b1;
        ctl.final_rnd = (cnt_r == 6'(NR));
        ctl.rk_idx    = decrypt ? 4'(NR - 32'(cnt_r)) : cnt_r[3:0];
        if (cnt_r == 6'(NR)) state_nxt = S_DONE;
        else cnt_nxt = cnt_r + 6'd1;
      end
      S_DONE: begin
        ctl.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_KEY;
    endcase
  end
endmodule

>>> rtl/core/aes_dp.sv
// Datapath: key schedule, round unit, chain register and padding count.
module aes_dp #(
  parameter int NK = 8,
  parameter int NR = 14
) (
  input  logic          clk,
  input  logic [255:0]  key,
  input  logic [127:0]  iv,
  input  logic          decrypt,
  input  logic          rst_chain,
  input  aes_pkg::ctl_t ctl,
  input  logic [127:0]  in_blk,
  input  logic          in_first,
  input  logic          in_last,
  output logic [127:0]  res,
  output logic [4:0]    kept,
  output logic          res_last
);
  // Window of the last NK schedule words; word 0 is the oldest.
  logic [31:0]  win_r [NK];
  logic [5:0]   wi_r;
  logic [2:0]   ph_r;
  logic [7:0]   rcon_r;
  logic [127:0] rk_mem [NR+1];
  logic [127:0] rkw_r;
  logic [127:0] rk_rd;
  logic [127:0] st_r, chain_r, cin_r;
  logic         last_r;
  logic [31:0]  t, wnew;

  // ph_r is the word index modulo NK.
  always_comb begin
    t = win_r[NK-1];
    if (ph_r == 3'd0) begin
      t = {aes_pkg::SBOX[t[23:16]] ^ rcon_r, aes_pkg::SBOX[t[15:8]],
           aes_pkg::SBOX[t[7:0]], aes_pkg::SBOX[t[31:24]]};
    end else if (NK > 6 && ph_r == 3'd4) begin
      t = {aes_pkg::SBOX[t[31:24]], aes_pkg::SBOX[t[23:16]],
           aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]};
    end
    wnew = (32'(wi_r) < NK) ? key[255-32*32'(ph_r) -: 32] : (win_r[0] ^ t);
  end

  always_ff @(posedge clk) begin
    if (ctl.key_step) begin
      if (ctl.key_clear) begin
        wi_r   <= 6'd1;
        ph_r   <= 3'd1;
        rcon_r <= 8'h01;
        for (int i = 0; i < NK-1; i++) win_r[i] <= win_r[i+1];
        win_r[NK-1] <= key[255 -: 32];
        rkw_r  <= {96'd0, key[255 -: 32]};
      end else begin
        wi_r <= wi_r + 6'd1;
        ph_r <= (ph_r == 3'(NK - 1)) ? 3'd0 : ph_r + 3'd1;
        if (ph_r == 3'd0 && 32'(wi_r) >= NK) rcon_r <= aes_pkg::xtime(rcon_r);
        for (int i = 0; i < NK-1; i++) win_r[i] <= win_r[i+1];
        win_r[NK-1] <= wnew;
        rkw_r <= {rkw_r[95:0], wnew};
        if (wi_r[1:0] == 2'd3) rk_mem[wi_r[5:2]] <= {rkw_r[95:0], wnew};
      end
    end
  end

  assign rk_rd = rk_mem[ctl.rk_idx];

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] n;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        n[127-8*(i+4*c) -: 8] = aes_pkg::SBOX[aes_pkg::bget(s, i + 4*((c+i)%4))];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = n[127-32*c -: 8]; a1 = n[119-32*c -: 8];
        a2 = n[111-32*c -: 8]; a3 = n[103-32*c -: 8];
        al = a0 ^ a1 ^ a2 ^ a3;
        n[127-32*c -: 8] = a0 ^ al ^ aes_pkg::xtime(a0 ^ a1);
        n[119-32*c -: 8] = a1 ^ al ^ aes_pkg::xtime(a1 ^ a2);
        n[111-32*c -: 8] = a2 ^ al ^ aes_pkg::xtime(a2 ^ a3);
        n[103-32*c -: 8] = a3 ^ al ^ aes_pkg::xtime(a3 ^ a0);
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] m9(input logic [7:0] a);
    logic [7:0] x2, x4, x8;
    x2 = aes_pkg::xtime(a); x4 = aes_pkg::xtime(x2); x8 = aes_pkg::xtime(x4);
    return x8 ^ a;
  endfunction

  // Inverse shift and sub bytes, add key, then inverse mix unless final.
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] n;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        n[127-8*(i+4*((c+i)%4)) -: 8] = aes_pkg::inv_sbox(aes_pkg::bget(s, i + 4*c));
    n = n ^ k;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        for (int j = 0; j < 4; j++) begin
          a[j]  = n[127-32*c-8*j -: 8];
          x2[j] = aes_pkg::xtime(a[j]);
          x4[j] = aes_pkg::xtime(x2[j]);
        end
        // 14=8^4^2, 11=8^2^1, 13=8^4^1, 9=8^1.
        for (int j = 0; j < 4; j++)
          n[127-32*c-8*j -: 8] = (m9(a[j]) ^ x4[j] ^ x2[j] ^ a[j])
                               ^ (m9(a[(j+1)%4]) ^ x2[(j+1)%4])
                               ^ (m9(a[(j+2)%4]) ^ x4[(j+2)%4])
                               ^ m9(a[(j+3)%4]);
      end
    end
    return n;
  endfunction

  logic [127:0] cur_chain, fin;
  logic [4:0]   kcnt;
  assign cur_chain = in_first ? iv : chain_r;
  assign fin = st_r ^ cin_r;

  always_comb begin
    kcnt = 5'd16;
    for (int i = 1; i < 16; i++) begin
      if (fin[127-8*i -: 8] == 8'h00 && fin[127-8*i+8 -: 8] != 8'h00 && kcnt == 5'd16)
        kcnt = 5'(i);
    end
    // Trailing run that reaches byte 1 leaves only byte 0.
    if (fin[119:0] == 120'd0) kcnt = 5'd1;
    else if (fin[7:0] != 8'h00) kcnt = 5'd16;
    else begin
      kcnt = 5'd16;
      for (int i = 15; i >= 1; i--) begin
        if (fin[127-8*i -: 8] == 8'h00 && kcnt == 5'(i+1)) kcnt = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_chain) chain_r <= '0;
    else if (ctl.load) chain_r <= decrypt ? in_blk : chain_r;
    else if (ctl.finish && !decrypt) chain_r <= st_r;
    if (ctl.load) begin
      last_r <= in_last;
      cin_r  <= decrypt ? cur_chain : '0;
      st_r   <= (decrypt ? in_blk : (in_blk ^ cur_chain)) ^ rk_rd;
    end else if (ctl.round) begin
      st_r <= decrypt ? dec_round(st_r, rk_rd, ctl.final_rnd)
                      : (enc_round(st_r, ctl.final_rnd) ^ rk_rd);
    end else if (ctl.finish) begin
      res      <= fin;
      kept     <= (decrypt && last_r) ? kcnt : 5'd16;
      res_last <= last_r;
    end
  end
endmodule

>>> tb/aes256_cbc_block_engine_tb.sv
// Self-checking testbench of the AES-256 CBC block engine, with an in-line predictor.
`timescale 1ns / 1ps

module aes256_cbc_block_engine_tb;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 4000;

  typedef aes_pkg::byte_t blk16_t [16];

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        first;
    logic        last;
  } block_item_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  kept;
    logic        last;
  } result_item_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  aes256_cbc_block_engine dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Predictor state.
  aes_pkg::byte_t inv_tab [256];
  aes_pkg::byte_t rkeys [15][16];
  logic        mdl_decrypt;
  logic [63:0] mdl_key [4];
  logic [63:0] mdl_iv_hi, mdl_iv_lo;
  blk16_t      mdl_chain;

  block_item_t  pending_blocks[$];
  result_item_t expected_results[$];
  int           fail_count;
  int           quiet_cycles;
  logic         in_took;
  logic         no_idle;
  int           send_gap, recv_gap;

  function automatic blk16_t to_bytes(input logic [63:0] hi, input logic [63:0] lo);
    blk16_t b;
    logic [127:0] v;
    v = {hi, lo};
    for (int k = 0; k < 16; k++) b[k] = v[127-8*k -: 8];
    return b;
  endfunction

  function automatic logic [127:0] from_bytes(input blk16_t b);
    logic [127:0] v;
    for (int k = 0; k < 16; k++) v[127-8*k -: 8] = b[k];
    return v;
  endfunction

  function automatic aes_pkg::byte_t dbl(input aes_pkg::byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic aes_pkg::byte_t gf_mul(input aes_pkg::byte_t a, input aes_pkg::byte_t b);
    aes_pkg::byte_t r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = dbl(a);
    end
    return r;
  endfunction

  function automatic void build_schedule();
    aes_pkg::byte_t kb [32];
    aes_pkg::byte_t w [60][4];
    aes_pkg::byte_t t [4];
    aes_pkg::byte_t rc, tmp;
    rc = 8'h01;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 8; j++) kb[8*i+j] = mdl_key[i][63-8*j -: 8];
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 4; j++) w[i][j] = kb[4*i+j];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        tmp = t[0];
        t[0] = aes_pkg::SBOX[t[1]] ^ rc;
        t[1] = aes_pkg::SBOX[t[2]];
        t[2] = aes_pkg::SBOX[t[3]];
        t[3] = aes_pkg::SBOX[tmp];
        rc = dbl(rc);
      end else if (i % 8 == 4) begin
        for (int j = 0; j < 4; j++) t[j] = aes_pkg::SBOX[t[j]];
      end
      for (int j = 0; j < 4; j++) w[i][j] = w[i-8][j] ^ t[j];
    end
    for (int i = 0; i < 60; i++)
      for (int j = 0; j < 4; j++) rkeys[i/4][4*(i%4)+j] = w[i][j];
  endfunction

  function automatic blk16_t cipher_fwd(input blk16_t s);
    blk16_t n;
    aes_pkg::byte_t a0, a1, a2, a3, al;
    for (int i = 0; i < 16; i++) s[i] ^= rkeys[0][i];
    for (int r = 1; r <= 14; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) n[i+4*c] = aes_pkg::SBOX[s[i+4*((c+i)%4)]];
      if (r != 14) begin
        for (int c = 0; c < 4; c++) begin
          a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          n[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
          n[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
          n[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
          n[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = n[i] ^ rkeys[r][i];
    end
    return s;
  endfunction

  function automatic blk16_t cipher_inv(input blk16_t s);
    blk16_t n;
    aes_pkg::byte_t a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) s[i] ^= rkeys[14][i];
    for (int r = 13; r >= 0; r--) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) n[i+4*((c+i)%4)] = inv_tab[s[i+4*c]];
      for (int i = 0; i < 16; i++) s[i] = n[i] ^ rkeys[r][i];
      if (r != 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                   ^ gf_mul(a3, 8'd9);
          s[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                   ^ gf_mul(a3, 8'd13);
          s[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                   ^ gf_mul(a3, 8'd11);
          s[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                   ^ gf_mul(a3, 8'd14);
        end
      end
    end
    return s;
  endfunction

  function automatic result_item_t cbc_step(input block_item_t it);
    result_item_t r;
    blk16_t blk, res;
    logic [127:0] v;
    logic stop;
    r.kept = 5'd16;
    stop = 1'b0;
    if (it.first) mdl_chain = to_bytes(mdl_iv_hi, mdl_iv_lo);
    blk = to_bytes(it.hi, it.lo);
    if (mdl_decrypt) begin
      res = cipher_inv(blk);
      for (int i = 0; i < 16; i++) res[i] ^= mdl_chain[i];
      mdl_chain = blk;
      if (it.last) begin
        for (int i = 15; i >= 1; i--) begin
          if (res[i] != 8'h00) stop = 1'b1;
          if (!stop) r.kept = 5'(i);
        end
      end
    end else begin
      for (int i = 0; i < 16; i++) res[i] = blk[i] ^ mdl_chain[i];
      res = cipher_fwd(res);
      mdl_chain = res;
    end
    v = from_bytes(res);
    r.hi = v[127:64];
    r.lo = v[63:0];
    r.last = it.last;
    return r;
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      aes_pkg::REG_MODE: mdl_decrypt = val[0];
      aes_pkg::REG_IVH:  mdl_iv_hi = val;
      aes_pkg::REG_IVL:  mdl_iv_lo = val;
      REG_UNUSED: ;
      default: begin
        mdl_key[2'(idx - aes_pkg::REG_KEY0)] = val;
        build_schedule();
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Monitor: checks results, tracks accepted items and registers.
  always @(posedge clk) begin
    result_item_t want;
    block_item_t  got_in;
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[63:0] !== want.hi) begin
            $error("result_high expected %h actual %h", want.hi, out_tdata[63:0]);
            fail_count++;
          end
          if (out_tdata[127:64] !== want.lo) begin
            $error("result_low expected %h actual %h", want.lo, out_tdata[127:64]);
            fail_count++;
          end
          if (out_tdata[132:128] !== want.kept) begin
            $error("kept_bytes expected %0d actual %0d", want.kept, out_tdata[132:128]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("result_last expected %b actual %b", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        got_in.hi = in_tdata[63:0];
        got_in.lo = in_tdata[127:64];
        got_in.first = in_tuser;
        got_in.last = in_tlast;
        expected_results = {expected_results, cbc_step(got_in)};
      end
    end
  end

  // Driver of the block channel.
  always @(negedge clk) begin
    block_item_t it;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (send_gap > 0 || pending_blocks.size() == 0) begin
        in_tvalid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        it = pending_blocks.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {it.lo, it.hi};
        in_tuser <= it.first;
        in_tlast <= it.last;
        send_gap <= pick_gap();
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_gap > 0) begin
        out_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_tready <= 1'b1;
        recv_gap <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_blocks.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo,
                             input logic first, input logic last);
    block_item_t it;
    it.hi = hi; it.lo = lo; it.first = first; it.last = last;
    pending_blocks = {pending_blocks, it};
  endtask

  // Queues a zero-padded message as ciphertext under the present key and IV.
  task automatic queue_padded_cipher(input int nblk, input int zeros);
    blk16_t chain, p;
    logic [127:0] v;
    chain = to_bytes(mdl_iv_hi, mdl_iv_lo);
    for (int b = 0; b < nblk; b++) begin
      v = {rand_word(), rand_word()};
      if (b == nblk - 1) for (int k = 0; k < zeros; k++) v[8*k +: 8] = 8'h00;
      p = to_bytes(v[127:64], v[63:0]);
      for (int i = 0; i < 16; i++) p[i] ^= chain[i];
      chain = cipher_fwd(p);
      v = from_bytes(chain);
      queue_block(v[127:64], v[63:0], b == 0, b == nblk - 1);
    end
  endtask

  task automatic set_key(input int pattern);
    for (int i = 0; i < 4; i++)
      write_reg(aes_pkg::REG_KEY0 + 3'(i),
                pattern == 0 ? 64'h0 : pattern == 1 ? '1 : rand_word());
  endtask

  initial begin
    int n, sent;
    for (int i = 0; i < 256; i++) inv_tab[aes_pkg::SBOX[i]] = 8'(i);
    mdl_decrypt = 1'b0;
    for (int i = 0; i < 4; i++) mdl_key[i] = 64'h0;
    mdl_iv_hi = 64'h0;
    mdl_iv_lo = 64'h0;
    for (int i = 0; i < 16; i++) mdl_chain[i] = 8'h00;
    build_schedule();
    fail_count = 0;
    quiet_cycles = 0;
    in_took = 1'b0;
    no_idle = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: no first block after reset, chain starts at zero.
    queue_block(64'h0, 64'h0, 1'b0, 1'b0);
    queue_block('1, '1, 1'b0, 1'b1);
    wait_drained();
    write_reg(aes_pkg::REG_IVH, '1);
    write_reg(aes_pkg::REG_IVL, 64'h0123456789abcdef);
    write_reg(REG_UNUSED, '1);
    set_key(1);
    queue_block(64'h0, '1, 1'b1, 1'b0);
    queue_block('1, 64'h0, 1'b0, 1'b1);
    wait_drained();
    // IV written mid-message, then key written mid-message.
    write_reg(aes_pkg::REG_IVH, 64'h0);
    queue_block(64'h00ff00ff00ff00ff, 64'h0, 1'b0, 1'b0);
    wait_drained();
    write_reg(aes_pkg::REG_KEY3, 64'hfedcba9876543210);
    queue_block(64'h1, 64'h8000000000000000, 1'b0, 1'b0);
    queue_block(64'h0, 64'h0, 1'b1, 1'b1);
    wait_drained();
    // Mode changed mid-message; the mode register only keeps its low bit.
    write_reg(aes_pkg::REG_MODE, 64'hffff_fffe);
    write_reg(aes_pkg::REG_MODE, 64'h3);
    queue_block(64'hdeadbeefcafef00d, 64'h0, 1'b0, 1'b0);
    wait_drained();
    // All-zero decrypted last block, then several trailing-zero counts.
    queue_padded_cipher(1, 16);
    queue_padded_cipher(2, 15);
    queue_padded_cipher(1, 0);
    queue_padded_cipher(3, 7);
    queue_block('1, '1, 1'b0, 1'b1);
    wait_drained();
    // Last block while encrypting keeps all bytes.
    write_reg(aes_pkg::REG_MODE, 64'h0);
    set_key(0);
    queue_block(64'h0, 64'h0, 1'b1, 1'b1);
    wait_drained();

    sent = 0;
    while (sent < 1850) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) set_key($urandom_range(0, 5));
      if ($urandom_range(0, 1) == 0) write_reg(aes_pkg::REG_IVH, rand_word());
      if ($urandom_range(0, 1) == 0) write_reg(aes_pkg::REG_IVL, rand_word());
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, rand_word());
      write_reg(aes_pkg::REG_MODE, {$urandom, $urandom});
      repeat ($urandom_range(2, 8)) begin
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 6) == 0) begin
          // Noise: loose first and last marks.
          for (int b = 0; b < n; b++)
            queue_block(rand_word(), rand_word(), $urandom_range(0, 1), $urandom_range(0, 1));
        end else if (mdl_decrypt && $urandom_range(0, 3) != 0) begin
          queue_padded_cipher(n, $urandom_range(0, 16));
        end else begin
          for (int b = 0; b < n; b++)
            queue_block(rand_word(), rand_word(), b == 0, b == n - 1);
        end
        sent += n;
      end
      wait_drained();
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/aes_pkg.sv
rtl/core/aes_ctrl.sv
rtl/core/aes_dp.sv
rtl/core/aes256_cbc_block_engine.sv
tb/aes256_cbc_block_engine_tb.sv
